>>> src/csr_pkg.sv
// ----------------------------------------------------------------------------
// csr_pkg: shared definitions for the complex square root block
// Widths, the front-to-back transaction type and one step of the
// digit-by-digit integer square root.
// ----------------------------------------------------------------------------
package csr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int SQ_W     = 2 * DATA_WIDTH;           // width of a^2 + b^2
  localparam int S1_STEPS = DATA_WIDTH;               // result bits of |z|
  localparam int SR_W     = DATA_WIDTH + 1;           // width of m +/- |a|
  localparam int S2_STEPS = (SR_W + FRAC_BITS) / 2;   // result bits of the root parts
  localparam int RAD2_W   = 2 * S2_STEPS;
  localparam int REM_W    = DATA_WIDTH + 3;
  localparam int RE_W     = 24;
  localparam int IM_W     = 25;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // One classified transaction: absolute values and signs of both parts.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] ua;
    logic [DATA_WIDTH-1:0] ub;
    logic                  a_neg;
    logic                  b_neg;
  } csr_item_t;

  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [DATA_WIDTH-1:0] root;
  } csr_sq_t;

  // One result bit: bring down two radicand bits and try root*4+1.
  function automatic csr_sq_t csr_sqrt_step(logic [REM_W-1:0] rem,
                                            logic [DATA_WIDTH-1:0] root,
                                            logic [1:0] pair);
    csr_sq_t          res;
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    cand  = {rem[REM_W-3:0], pair};
    trial = {1'b0, root, 2'b01};
    if (cand >= trial) begin
      res.rem  = cand - trial;
      res.root = {root[DATA_WIDTH-2:0], 1'b1};
    end else begin
      res.rem  = cand;
      res.root = {root[DATA_WIDTH-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

>>> src/csr_front.sv
// ----------------------------------------------------------------------------
// csr_front: input stage
// Registers each transaction and splits both parts into magnitude and sign.
// ----------------------------------------------------------------------------
module csr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [csr_pkg::DATA_WIDTH-1:0] re_in_i,
  input  logic [csr_pkg::DATA_WIDTH-1:0] im_in_i,
  output logic                           item_valid_o,
  input  logic                           item_ready_i,
  output csr_pkg::csr_item_t             item_o
);

  logic               vld_q;
  csr_pkg::csr_item_t item_q, item_d;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_comb begin
    item_d.a_neg = re_in_i[csr_pkg::DATA_WIDTH-1];
    item_d.b_neg = im_in_i[csr_pkg::DATA_WIDTH-1];
    item_d.ua    = item_d.a_neg ? (~re_in_i + 1'b1) : re_in_i;
    item_d.ub    = item_d.b_neg ? (~im_in_i + 1'b1) : im_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

>>> src/csr_fifo.sv
// ----------------------------------------------------------------------------
// csr_fifo: short queue between front and back
// Lets the front keep accepting while the back pipeline is stalled.
// ----------------------------------------------------------------------------
module csr_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  csr_pkg::csr_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output csr_pkg::csr_item_t pop_item_o
);

  csr_pkg::csr_item_t          mem_q [csr_pkg::FIFO_DEPTH];
  logic [csr_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
  logic [csr_pkg::FIFO_AW:0]   cnt_q, cnt_d;
  logic                        push, pop;

  assign push_ready_o = (cnt_q != csr_pkg::FIFO_AW'(0) + (csr_pkg::FIFO_AW+1)'(csr_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

>>> src/csr_back.sv
// ----------------------------------------------------------------------------
// csr_back: arithmetic pipeline
// Squares, sums, takes |z| one bit per stage, forms m +/- |a|, then both
// root parts in parallel one bit per stage; all stages advance together.
// ----------------------------------------------------------------------------
module csr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  csr_pkg::csr_item_t              item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [csr_pkg::RE_W-1:0]        root_re_o,
  output logic [csr_pkg::IM_W-1:0]        root_im_o,
  output logic [csr_pkg::DATA_WIDTH-1:0]  magnitude_o
);

  localparam int DW = csr_pkg::DATA_WIDTH;
  localparam int S1 = csr_pkg::S1_STEPS;
  localparam int S2 = csr_pkg::S2_STEPS;

  logic adv;

  // Squaring stage.
  logic                         a_vld_q;
  logic [csr_pkg::SQ_W-1:0]     a_sqa_q, a_sqb_q;
  logic [DW-1:0]                a_ua_q;
  logic                         a_an_q, a_bn_q;
  // Sum stage.
  logic                         b_vld_q;
  logic [csr_pkg::SQ_W-1:0]     b_rad_q;
  logic [DW-1:0]                b_ua_q;
  logic                         b_an_q, b_bn_q;
  // Magnitude root stages.
  logic                         s1_vld_q  [S1];
  logic [csr_pkg::REM_W-1:0]    s1_rem_q  [S1];
  logic [DW-1:0]                s1_root_q [S1];
  logic [csr_pkg::SQ_W-1:0]     s1_rad_q  [S1];
  logic [DW-1:0]                s1_ua_q   [S1];
  logic                         s1_an_q   [S1];
  logic                         s1_bn_q   [S1];
  // Sum and difference stage.
  logic                         c_vld_q;
  logic [csr_pkg::SR_W-1:0]     c_s_q, c_t_q;
  logic [DW-1:0]                c_m_q;
  logic                         c_bn_q;
  // Root part stages, unit x for the real part and unit y for the imaginary.
  logic                         s2_vld_q   [S2];
  logic [csr_pkg::REM_W-1:0]    s2_xrem_q  [S2];
  logic [DW-1:0]                s2_xroot_q [S2];
  logic [csr_pkg::RAD2_W-1:0]   s2_xrad_q  [S2];
  logic [csr_pkg::REM_W-1:0]    s2_yrem_q  [S2];
  logic [DW-1:0]                s2_yroot_q [S2];
  logic [csr_pkg::RAD2_W-1:0]   s2_yrad_q  [S2];
  logic [DW-1:0]                s2_m_q     [S2];
  logic                         s2_bn_q    [S2];
  // Output register.
  logic                         o_vld_q;
  logic [csr_pkg::RE_W-1:0]     o_re_q;
  logic [csr_pkg::IM_W-1:0]     o_im_q;
  logic [DW-1:0]                o_mag_q;

  assign adv          = !o_vld_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = o_vld_q;
  assign root_re_o    = o_re_q;
  assign root_im_o    = o_im_q;
  assign magnitude_o  = o_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= item_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= s1_vld_q[S1-1];
      o_vld_q <= s2_vld_q[S2-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_sqa_q <= item_i.ua * item_i.ua;
      a_sqb_q <= item_i.ub * item_i.ub;
      a_ua_q  <= item_i.ua;
      a_an_q  <= item_i.a_neg;
      a_bn_q  <= item_i.b_neg;
      b_rad_q <= a_sqa_q + a_sqb_q;
      b_ua_q  <= a_ua_q;
      b_an_q  <= a_an_q;
      b_bn_q  <= a_bn_q;
    end
  end

  for (genvar k = 0; k < S1; k++) begin : g_s1
    logic                      vld_in;
    logic [csr_pkg::REM_W-1:0] rem_in;
    logic [DW-1:0]             root_in;
    logic [csr_pkg::SQ_W-1:0]  rad_in;
    logic [DW-1:0]             ua_in;
    logic                      an_in, bn_in;
    csr_pkg::csr_sq_t          step;

    if (k == 0) begin : g_first
      assign vld_in  = b_vld_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = b_rad_q;
      assign ua_in   = b_ua_q;
      assign an_in   = b_an_q;
      assign bn_in   = b_bn_q;
    end else begin : g_next
      assign vld_in  = s1_vld_q[k-1];
      assign rem_in  = s1_rem_q[k-1];
      assign root_in = s1_root_q[k-1];
      assign rad_in  = s1_rad_q[k-1];
      assign ua_in   = s1_ua_q[k-1];
      assign an_in   = s1_an_q[k-1];
      assign bn_in   = s1_bn_q[k-1];
    end

    assign step = csr_pkg::csr_sqrt_step(rem_in, root_in,
                                         rad_in[csr_pkg::SQ_W-1 -: 2]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_vld_q[k] <= 1'b0;
      end else if (adv) begin
        s1_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s1_rem_q[k]  <= step.rem;
        s1_root_q[k] <= step.root;
        s1_rad_q[k]  <= {rad_in[csr_pkg::SQ_W-3:0], 2'b00};
        s1_ua_q[k]   <= ua_in;
        s1_an_q[k]   <= an_in;
        s1_bn_q[k]   <= bn_in;
      end
    end
  end

  // m >= |a|, so neither difference can go negative.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_m_q  <= s1_root_q[S1-1];
      c_bn_q <= s1_bn_q[S1-1];
      if (s1_an_q[S1-1]) begin
        c_s_q <= {1'b0, s1_root_q[S1-1]} - {1'b0, s1_ua_q[S1-1]};
        c_t_q <= {1'b0, s1_root_q[S1-1]} + {1'b0, s1_ua_q[S1-1]};
      end else begin
        c_s_q <= {1'b0, s1_root_q[S1-1]} + {1'b0, s1_ua_q[S1-1]};
        c_t_q <= {1'b0, s1_root_q[S1-1]} - {1'b0, s1_ua_q[S1-1]};
      end
    end
  end

  for (genvar k = 0; k < S2; k++) begin : g_s2
    logic                       vld_in;
    logic [csr_pkg::REM_W-1:0]  xrem_in, yrem_in;
    logic [DW-1:0]              xroot_in, yroot_in;
    logic [csr_pkg::RAD2_W-1:0] xrad_in, yrad_in;
    logic [DW-1:0]              m_in;
    logic                       bn_in;
    csr_pkg::csr_sq_t           xstep, ystep;

    if (k == 0) begin : g_first
      assign vld_in   = c_vld_q;
      assign xrem_in  = '0;
      assign yrem_in  = '0;
      assign xroot_in = '0;
      assign yroot_in = '0;
      assign xrad_in  = csr_pkg::RAD2_W'({c_s_q, {(csr_pkg::FRAC_BITS-1){1'b0}}});
      assign yrad_in  = csr_pkg::RAD2_W'({c_t_q, {(csr_pkg::FRAC_BITS-1){1'b0}}});
      assign m_in     = c_m_q;
      assign bn_in    = c_bn_q;
    end else begin : g_next
      assign vld_in   = s2_vld_q[k-1];
      assign xrem_in  = s2_xrem_q[k-1];
      assign yrem_in  = s2_yrem_q[k-1];
      assign xroot_in = s2_xroot_q[k-1];
      assign yroot_in = s2_yroot_q[k-1];
      assign xrad_in  = s2_xrad_q[k-1];
      assign yrad_in  = s2_yrad_q[k-1];
      assign m_in     = s2_m_q[k-1];
      assign bn_in    = s2_bn_q[k-1];
    end

    assign xstep = csr_pkg::csr_sqrt_step(xrem_in, xroot_in,
                                          xrad_in[csr_pkg::RAD2_W-1 -: 2]);
    assign ystep = csr_pkg::csr_sqrt_step(yrem_in, yroot_in,
                                          yrad_in[csr_pkg::RAD2_W-1 -: 2]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s2_vld_q[k] <= 1'b0;
      end else if (adv) begin
        s2_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s2_xrem_q[k]  <= xstep.rem;
        s2_xroot_q[k] <= xstep.root;
        s2_xrad_q[k]  <= {xrad_in[csr_pkg::RAD2_W-3:0], 2'b00};
        s2_yrem_q[k]  <= ystep.rem;
        s2_yroot_q[k] <= ystep.root;
        s2_yrad_q[k]  <= {yrad_in[csr_pkg::RAD2_W-3:0], 2'b00};
        s2_m_q[k]     <= m_in;
        s2_bn_q[k]    <= bn_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_mag_q <= s2_m_q[S2-1];
      o_re_q  <= s2_xroot_q[S2-1][csr_pkg::RE_W-1:0];
      if (s2_bn_q[S2-1]) begin
        o_im_q <= ~{1'b0, s2_yroot_q[S2-1][csr_pkg::RE_W-1:0]} + 1'b1;
      end else begin
        o_im_q <= {1'b0, s2_yroot_q[S2-1][csr_pkg::RE_W-1:0]};
      end
    end
  end

endmodule

>>> src/complex_square_root_top.sv
// ----------------------------------------------------------------------------
// complex_square_root_top: complex principal square root and modulus
// Returns |z| and the principal root of a signed Q16.16 complex number.
// ----------------------------------------------------------------------------
// Pipeline: the 32 one-bit stages of the magnitude root and the 24 one-bit
//   stages of the root parts, plus input, queue, square, sum, difference and
//   output registers.
// Throughput: one transaction per cycle while the output is not stalled;
//   each root stage resolves one bit.
// Reset: rst_ni clears all valid flags and queue pointers at once.
module complex_square_root_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [csr_pkg::DATA_WIDTH-1:0] re_in_i,
  input  logic [csr_pkg::DATA_WIDTH-1:0] im_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [csr_pkg::RE_W-1:0]       root_re_o,
  output logic [csr_pkg::IM_W-1:0]       root_im_o,
  output logic [csr_pkg::DATA_WIDTH-1:0] magnitude_o
);

  // The front registers each transaction and turns both parts into an
  // absolute value plus a sign flag.
  logic               f_valid, f_ready;
  csr_pkg::csr_item_t f_item;
  // The queue output feeds the back pipeline.
  logic               q_valid, q_ready;
  csr_pkg::csr_item_t q_item;

  csr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .re_in_i      (re_in_i),
    .im_in_i      (im_in_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  // A short queue decouples the two sides, so that the front keeps taking
  // transactions while the result register is held, until the queue is full.
  csr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // The back pipeline advances as a whole whenever its output register is
  // empty or being read, and holds every stage otherwise.
  csr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .root_re_o    (root_re_o),
    .root_im_o    (root_im_o),
    .magnitude_o  (magnitude_o)
  );

endmodule

>>> src/csr_checker.sv
// ----------------------------------------------------------------------------
// csr_checker: port-level checks for the complex square root block
// Watches the top-level ports and flags illegal behavior over time.
// ----------------------------------------------------------------------------
module csr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [csr_pkg::DATA_WIDTH-1:0] re_in_i,
  input logic [csr_pkg::DATA_WIDTH-1:0] im_in_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [csr_pkg::RE_W-1:0]       root_re_o,
  input logic [csr_pkg::IM_W-1:0]       root_im_o,
  input logic [csr_pkg::DATA_WIDTH-1:0] magnitude_o
);

  // A stalled result stays offered with its payload unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_re_o) &&
    $stable(root_im_o) && $stable(magnitude_o))
    else $error("result changed while stalled");

  // A stalled input transaction stays offered.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input dropped while stalled");

  // No result can appear in the first cycle out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

  // Only the zero input gives a zero modulus, and only it gives a zero root.
  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((magnitude_o == '0) == ((root_re_o == '0) && (root_im_o == '0))))
    else $error("root and modulus disagree on zero");

endmodule

bind complex_square_root_top csr_checker u_csr_checker (.*);

>>> bench/complex_square_root_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_square_root_checker: result predictor and scoreboard
// Watches both channels, computes the expected modulus and principal root
// of every accepted input transaction and compares each output transaction
// with the oldest expectation.
// ----------------------------------------------------------------------------
module complex_square_root_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [csr_pkg::DATA_WIDTH-1:0] re_in_i,
  input  logic [csr_pkg::DATA_WIDTH-1:0] im_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [csr_pkg::RE_W-1:0]       root_re_i,
  input  logic [csr_pkg::IM_W-1:0]       root_im_i,
  input  logic [csr_pkg::DATA_WIDTH-1:0] magnitude_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_seen_o
);

  typedef struct packed {
    logic [csr_pkg::RE_W-1:0]       root_re;
    logic [csr_pkg::IM_W-1:0]       root_im;
    logic [csr_pkg::DATA_WIDTH-1:0] magnitude;
  } root_result_t;

  root_result_t expected_roots[$];

  // Integer square root truncating toward zero, one result bit at a time.
  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
      c = r | (64'd1 << bit_idx);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic root_result_t predict_root(
      logic [csr_pkg::DATA_WIDTH-1:0] re_raw,
      logic [csr_pkg::DATA_WIDTH-1:0] im_raw);
    root_result_t res;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  m;
    logic [63:0]  s;
    logic [63:0]  t;
    logic [63:0]  re;
    logic [63:0]  im;
    ua = 64'(re_raw);
    ub = 64'(im_raw);
    if (re_raw[csr_pkg::DATA_WIDTH-1]) ua = 64'(~re_raw) + 64'd1 & 64'hFFFF_FFFF;
    if (im_raw[csr_pkg::DATA_WIDTH-1]) ub = 64'(~im_raw) + 64'd1 & 64'hFFFF_FFFF;
    m = isqrt128({64'd0, ua} * {64'd0, ua} + {64'd0, ub} * {64'd0, ub});
    if (re_raw[csr_pkg::DATA_WIDTH-1]) begin
      s = m - ua;
      t = m + ua;
    end else begin
      s = m + ua;
      t = m - ua;
    end
    re = isqrt128({64'd0, s} << (csr_pkg::FRAC_BITS - 1));
    im = isqrt128({64'd0, t} << (csr_pkg::FRAC_BITS - 1));
    if (re > 64'hFF_FFFF) re = 64'hFF_FFFF;
    if (im > 64'hFF_FFFF) im = 64'hFF_FFFF;
    // The imaginary part of the root follows the sign of the input.
    if (im_raw[csr_pkg::DATA_WIDTH-1]) im = -im;
    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
    res.root_re   = re[csr_pkg::RE_W-1:0];
    res.root_im   = im[csr_pkg::IM_W-1:0];
    res.magnitude = m[csr_pkg::DATA_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    root_result_t want;
    if (!rst_ni) begin
      fail_count_o   <= 0;
      results_seen_o <= 0;
      expected_roots.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        expected_roots.push_back(predict_root(re_in_i, im_in_i));
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_roots.size() == 0) begin
          $error("unexpected result transaction");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_roots.pop_front();
          if (want.root_re !== root_re_i) begin
            $error("root_re expected %0h actual %0h", want.root_re, root_re_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (want.root_im !== root_im_i) begin
            $error("root_im expected %0h actual %0h", want.root_im, root_im_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (want.magnitude !== magnitude_i) begin
            $error("magnitude expected %0h actual %0h", want.magnitude, magnitude_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_roots.size();

endmodule

>>> bench/complex_square_root_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_square_root_top_tb: stimulus and verdict for the complex root block
// Sends directed corner values and then random complex numbers with random
// gaps on both sides, including one long output stall, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module complex_square_root_top_tb;

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [csr_pkg::DATA_WIDTH-1:0] re_in = '0;
  logic [csr_pkg::DATA_WIDTH-1:0] im_in = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [csr_pkg::RE_W-1:0]       root_re;
  logic [csr_pkg::IM_W-1:0]       root_im;
  logic [csr_pkg::DATA_WIDTH-1:0] magnitude;
  int                             fail_count;
  int                             pending;
  int                             results_seen;
  int                             items_sent = 0;
  bit                             hold_off_done = 1'b0;
  int                             idle_cycles = 0;

  // The clock runs with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  complex_square_root_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .re_in_i(re_in), .im_in_i(im_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .root_re_o(root_re), .root_im_o(root_im), .magnitude_o(magnitude)
  );

  complex_square_root_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .re_in_i(re_in), .im_in_i(im_in),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .root_re_i(root_re), .root_im_i(root_im), .magnitude_i(magnitude),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Offers one transaction after a random gap and holds it until accepted.
  // Valid stays high straight into the next transaction when no gap is drawn.
  task automatic send_complex(logic [csr_pkg::DATA_WIDTH-1:0] re_val,
                              logic [csr_pkg::DATA_WIDTH-1:0] im_val);
    int gap;
    gap = (items_sent % 60 < 15) ? 0 : $urandom_range(19, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    re_in    <= re_val;
    im_in    <= im_val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Random value biased toward the extremes and small magnitudes.
  function automatic logic [csr_pkg::DATA_WIDTH-1:0] pick_part();
    case ($urandom_range(7, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return 32'($signed($urandom_range(1024, 0)) - 512);
      default: return $urandom();
    endcase
  endfunction

  // The receiver stalls at random; once, it holds off for a long stretch so
  // the pipeline fills up and pushes back on the sender.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (!hold_off_done && items_sent > 150) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_done = 1'b1;
      end
      stall = (results_seen % 50 < 12) ? 0 : $urandom_range(19, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: the run ends if nothing is accepted for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [csr_pkg::DATA_WIDTH-1:0] corners[8];
    corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0004_0000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Zero imaginary part on both signs of the real part, and signs of b.
    foreach (corners[i]) send_complex(corners[i], 32'h0);
    send_complex(32'h0, 32'h8000_0000);
    send_complex(32'h0, 32'h7FFF_FFFF);
    send_complex(32'h8000_0000, 32'h8000_0000);
    send_complex(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_complex(32'h8000_0000, 32'h7FFF_FFFF);
    send_complex(32'h7FFF_FFFF, 32'h8000_0000);
    send_complex(32'h0003_0000, 32'h0004_0000);
    send_complex(32'hFFFD_0000, 32'hFFFC_0000);
    send_complex(32'hFFFF_FFFF, 32'h0000_0001);
    send_complex(32'h0000_0001, 32'hFFFF_FFFF);
    send_complex(32'hAAAA_AAAA, 32'h5555_5555);
    send_complex(32'h5555_5555, 32'hAAAA_AAAA);
    for (int n = 0; n < RANDOM_ITEMS; n++) send_complex(pick_part(), pick_part());
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d complex transactions and checked %0d results,", items_sent,
             results_seen);
    $display("covering corner values, random gaps and a long output stall.");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
src/csr_pkg.sv
src/csr_front.sv
src/csr_fifo.sv
src/csr_back.sv
src/complex_square_root_top.sv
src/csr_checker.sv
bench/complex_square_root_checker.sv
bench/complex_square_root_top_tb.sv
